// File: src/setr_pkg.sv
// Shared types and constants for the sequenced event trace ring.
`default_nettype none
package setr_pkg;

    localparam int SER_W   = 64;
    localparam int EPOCH_W = 32;
    localparam int TYPE_W  = 4;
    localparam int ADDR_W  = 64;
    localparam int DATA_W  = 32;
    localparam int KIND_W  = 2;

    localparam logic       FUNC_RECORD = 1'b0;
    localparam logic       FUNC_READ   = 1'b1;

    localparam logic [KIND_W-1:0] KIND_ACK   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EVENT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SUM   = 2'd2;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } t_alu_op;

    typedef struct packed {
        logic [SER_W-1:0] a;
        logic [SER_W-1:0] b;
        t_alu_op          op;
    } t_alu_req;

    typedef struct packed {
        logic [SER_W-1:0] sum;
        logic             carry;
    } t_alu_rsp;

    typedef struct packed {
        logic [EPOCH_W-1:0] epoch;
        logic [TYPE_W-1:0]  etype;
        logic [ADDR_W-1:0]  address;
        logic [DATA_W-1:0]  actor_index;
        logic [DATA_W-1:0]  sector;
        logic [DATA_W-1:0]  old_stat;
        logic [DATA_W-1:0]  new_stat;
    } t_slot;

    localparam int SLOT_W = $bits(t_slot);

endpackage
`default_nettype wire

// File: src/sequenced_event_trace_ring_unit.sv
// Top level of the sequenced event trace ring: sequencer, slot RAM and shared adder.
//
// A ring of DEPTH event slots. A record beat (func 0) never raises busy, so
// records may arrive every cycle, and each one returns an acknowledge strobe in
// the next cycle carrying its 64-bit serial. A read beat (func 1) raises busy
// and walks the ring: the setup states (oldest serial, cursor checks, start
// slot, RAM prime), then one event beat per cycle, then the summary beat; the
// run goes straight to the summary when the ring is empty or the cursor is
// current. The setup length and the one-per-cycle event rate are set by the
// single shared 64-bit adder, which does every wide add and compare in turn,
// and by the registered read port of the slot RAM. Results are presented for
// exactly one cycle on o_valid and cannot be stalled. The reset_type_code
// register may be written only while the block is idle.
`default_nettype none
module sequenced_event_trace_ring_unit
    import setr_pkg::*;
#(
    parameter int DEPTH = 32
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic                      i_cfg_we,
    input  wire logic [TYPE_W-1:0]         i_cfg_wdata,
    input  wire logic                      i_func,
    input  wire logic [TYPE_W-1:0]         i_event_type,
    input  wire logic [ADDR_W-1:0]         i_actor_address,
    input  wire logic signed [DATA_W-1:0]  i_actor_index,
    input  wire logic signed [DATA_W-1:0]  i_old_stat,
    input  wire logic signed [DATA_W-1:0]  i_new_stat,
    input  wire logic signed [DATA_W-1:0]  i_sector_index,
    input  wire logic [SER_W-1:0]          i_cursor,
    output logic                           o_valid,
    output logic [KIND_W-1:0]              o_kind,
    output logic [SER_W-1:0]               o_serial,
    output logic [SER_W-1:0]               o_oldest_serial,
    output logic                           o_overflowed,
    output logic [EPOCH_W-1:0]             o_epoch,
    output logic [TYPE_W-1:0]              o_out_type,
    output logic [ADDR_W-1:0]              o_out_address,
    output logic signed [DATA_W-1:0]       o_out_actor_index,
    output logic signed [DATA_W-1:0]       o_out_sector,
    output logic signed [DATA_W-1:0]       o_out_old_stat,
    output logic signed [DATA_W-1:0]       o_out_new_stat
);
    // slot index width and count width (count must hold DEPTH itself)
    localparam int AW = $clog2(DEPTH > 1 ? DEPTH : 2);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_BASE,     // base = latest - fill (oldest - 1)
        S_OLDEST,   // oldest = base + 1
        S_CHKCUR,   // cursor >= latest: nothing to emit
        S_CHKOVR,   // cursor < base: overwritten events skipped
        S_SETUP,    // first serial, count and start slot
        S_PRIME,    // issue first RAM read
        S_EMIT,     // one event beat per cycle
        S_SUM       // summary beat ends the run
    } t_state;

    t_state              r_state, n_state;
    logic [TYPE_W-1:0]   r_code, n_code;
    logic [SER_W-1:0]    r_latest, n_latest;
    logic [EPOCH_W-1:0]  r_epoch, n_epoch;
    logic [CW-1:0]       r_fill, n_fill;
    logic [AW-1:0]       r_wp, n_wp;
    logic [SER_W-1:0]    r_cursor, n_cursor;
    logic [SER_W-1:0]    r_base, n_base;
    logic [SER_W-1:0]    r_oldest, n_oldest;
    logic                r_over, n_over;
    logic [SER_W-1:0]    r_s, n_s;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic [AW-1:0]       r_idx, n_idx;

    logic                r_valid, n_valid;
    logic [KIND_W-1:0]   r_kind, n_kind;
    logic [SER_W-1:0]    r_serial, n_serial;
    logic [SER_W-1:0]    r_oldest_o, n_oldest_o;
    logic                r_over_o, n_over_o;
    t_slot               r_data, n_data;

    t_alu_req            alu_req;
    t_alu_rsp            alu_rsp;

    logic                accept;
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    t_slot               ram_wdata;
    t_slot               ram_rdata;

    logic [EPOCH_W-1:0]  epoch_inc;
    logic [AW-1:0]       w_slot;
    logic [CW-1:0]       cnt_first;
    logic [CW:0]         start_sum;

    setr_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    setr_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    // route the shared adder by sequencer step
    always_comb begin
        alu_req.a  = r_latest;
        alu_req.b  = SER_W'(1);
        alu_req.op = ALU_ADD;
        case (r_state)
            S_IDLE: begin
                alu_req.a  = r_latest;
                alu_req.b  = SER_W'(1);
                alu_req.op = ALU_ADD;
            end
            S_BASE: begin
                alu_req.a  = r_latest;
                alu_req.b  = SER_W'(r_fill);
                alu_req.op = ALU_SUB;
            end
            S_OLDEST: begin
                alu_req.a  = r_base;
                alu_req.b  = SER_W'(1);
                alu_req.op = ALU_ADD;
            end
            S_CHKCUR: begin
                alu_req.a  = r_cursor;
                alu_req.b  = r_latest;
                alu_req.op = ALU_SUB;
            end
            S_CHKOVR: begin
                alu_req.a  = r_cursor;
                alu_req.b  = r_base;
                alu_req.op = ALU_SUB;
            end
            S_SETUP: begin
                alu_req.a  = r_cursor;
                alu_req.b  = SER_W'(1);
                alu_req.op = ALU_ADD;
            end
            S_EMIT: begin
                alu_req.a  = r_s;
                alu_req.b  = SER_W'(1);
                alu_req.op = ALU_ADD;
            end
            default: begin
                alu_req.a  = r_latest;
                alu_req.b  = SER_W'(1);
                alu_req.op = ALU_ADD;
            end
        endcase
    end

    // record path: bump epoch on the reset type, skip zero on wrap
    assign epoch_inc = (r_epoch + EPOCH_W'(1) == '0) ? EPOCH_W'(1) : r_epoch + EPOCH_W'(1);
    // a serial wrap restarts the ring at slot 0
    assign w_slot    = alu_rsp.carry ? '0 : r_wp;

    assign ram_we    = accept && (i_func == FUNC_RECORD);
    assign ram_waddr = w_slot;
    always_comb begin
        ram_wdata.epoch       = (i_event_type == r_code) ? epoch_inc : r_epoch;
        ram_wdata.etype       = i_event_type;
        ram_wdata.address     = i_actor_address;
        ram_wdata.actor_index = i_actor_index;
        ram_wdata.sector      = i_sector_index;
        ram_wdata.old_stat    = i_old_stat;
        ram_wdata.new_stat    = i_new_stat;
    end

    // events to emit: all available ones on overflow, else latest - cursor
    // (below 2**CW, so the low bits give it exactly)
    assign cnt_first = r_over ? r_fill : (r_latest[CW-1:0] - r_cursor[CW-1:0]);
    // oldest emitted slot = write pointer - count, modulo DEPTH
    assign start_sum = (CW + 1)'(r_wp) + (CW + 1)'(DEPTH) - (CW + 1)'(cnt_first);

    always_comb begin
        n_state    = r_state;
        n_code     = i_cfg_we ? i_cfg_wdata : r_code;
        n_latest   = r_latest;
        n_epoch    = r_epoch;
        n_fill     = r_fill;
        n_wp       = r_wp;
        n_cursor   = r_cursor;
        n_base     = r_base;
        n_oldest   = r_oldest;
        n_over     = r_over;
        n_s        = r_s;
        n_cnt      = r_cnt;
        n_idx      = r_idx;
        n_valid    = 1'b0;
        n_kind     = KIND_ACK;
        n_serial   = '0;
        n_oldest_o = '0;
        n_over_o   = 1'b0;
        n_data     = '0;

        case (r_state)
            S_IDLE: begin
                if (accept && (i_func == FUNC_RECORD)) begin
                    n_epoch = ram_wdata.epoch;
                    if (alu_rsp.carry) begin
                        n_latest = SER_W'(1);
                        n_fill   = CW'(1);
                    end else begin
                        n_latest = alu_rsp.sum;
                        n_fill   = (r_fill < CW'(DEPTH)) ? r_fill + CW'(1) : r_fill;
                    end
                    n_wp     = (w_slot == AW'(DEPTH - 1)) ? '0 : w_slot + AW'(1);
                    n_valid  = 1'b1;
                    n_kind   = KIND_ACK;
                    n_serial = alu_rsp.carry ? SER_W'(1) : alu_rsp.sum;
                end else if (accept) begin
                    n_cursor = i_cursor;
                    n_over   = 1'b0;
                    n_state  = S_BASE;
                end
            end
            S_BASE: begin
                n_base = alu_rsp.sum;
                if (r_fill == '0) begin
                    n_oldest = '0;
                    n_state  = S_SUM;
                end else begin
                    n_state  = S_OLDEST;
                end
            end
            S_OLDEST: begin
                n_oldest = alu_rsp.sum;
                n_state  = S_CHKCUR;
            end
            S_CHKCUR: begin
                // no borrow: cursor already at or past latest
                n_state = alu_rsp.carry ? S_SUM : S_CHKOVR;
            end
            S_CHKOVR: begin
                n_over  = !alu_rsp.carry;
                n_state = S_SETUP;
            end
            S_SETUP: begin
                n_s     = r_over ? r_oldest : alu_rsp.sum;
                n_cnt   = cnt_first;
                n_idx   = (start_sum >= (CW + 1)'(DEPTH))
                        ? AW'(start_sum - (CW + 1)'(DEPTH)) : AW'(start_sum);
                n_state = S_PRIME;
            end
            S_PRIME: begin
                n_idx   = (r_idx == AW'(DEPTH - 1)) ? '0 : r_idx + AW'(1);
                n_state = S_EMIT;
            end
            S_EMIT: begin
                n_valid  = 1'b1;
                n_kind   = KIND_EVENT;
                n_serial = r_s;
                n_data   = ram_rdata;
                n_s      = alu_rsp.sum;
                n_cnt    = r_cnt - CW'(1);
                n_idx    = (r_idx == AW'(DEPTH - 1)) ? '0 : r_idx + AW'(1);
                if (r_cnt == CW'(1)) begin
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                n_valid    = 1'b1;
                n_kind     = KIND_SUM;
                n_serial   = r_latest;
                n_oldest_o = r_oldest;
                n_over_o   = r_over;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        // payload: no reset needed
        r_cursor   <= n_cursor;
        r_base     <= n_base;
        r_oldest   <= n_oldest;
        r_over     <= n_over;
        r_s        <= n_s;
        r_cnt      <= n_cnt;
        r_idx      <= n_idx;
        r_kind     <= n_kind;
        r_serial   <= n_serial;
        r_oldest_o <= n_oldest_o;
        r_over_o   <= n_over_o;
        r_data     <= n_data;
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_code   <= '0;
            r_latest <= '0;
            r_epoch  <= '0;
            r_fill   <= '0;
            r_wp     <= '0;
            r_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_code   <= n_code;
            r_latest <= n_latest;
            r_epoch  <= n_epoch;
            r_fill   <= n_fill;
            r_wp     <= n_wp;
            r_valid  <= n_valid;
        end
    end

    assign o_valid           = r_valid;
    assign o_kind            = r_kind;
    assign o_serial          = r_serial;
    assign o_oldest_serial   = r_oldest_o;
    assign o_overflowed      = r_over_o;
    assign o_epoch           = r_data.epoch;
    assign o_out_type        = r_data.etype;
    assign o_out_address     = r_data.address;
    assign o_out_actor_index = r_data.actor_index;
    assign o_out_sector      = r_data.sector;
    assign o_out_old_stat    = r_data.old_stat;
    assign o_out_new_stat    = r_data.new_stat;

    // fill count never passes the ring size
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(DEPTH))
        else $error("fill count exceeds ring depth");

    // a record beat is acknowledged on the next cycle
    a_rec_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_func == FUNC_RECORD) |=> o_valid && (o_kind == KIND_ACK))
        else $error("record beat not acknowledged");

    // event beats only come out of the emit step
    a_event_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == KIND_EVENT) |-> $past(r_state) == S_EMIT)
        else $error("event beat outside emit step");

    // the summary closes the read run and frees the block
    a_sum_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == KIND_SUM) |-> !busy)
        else $error("block still busy after summary");

    // nothing is emitted while the read is still in setup
    a_setup_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OLDEST || r_state == S_CHKCUR || r_state == S_CHKOVR
         || r_state == S_SETUP || r_state == S_PRIME) |-> !o_valid)
        else $error("beat emitted during read setup");
endmodule
`default_nettype wire

// File: src/setr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module setr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_we,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                      i_wdata,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                      o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: src/setr_alu.sv
// Shared 64-bit add/subtract unit with carry out.
`default_nettype none
module setr_alu
    import setr_pkg::*;
(
    input  wire t_alu_req i_req,
    output t_alu_rsp      o_rsp
);
    logic [SER_W-1:0] b_eff;
    logic [SER_W:0]   full;

    always_comb begin
        b_eff = (i_req.op == ALU_SUB) ? ~i_req.b : i_req.b;
        // carry out of a subtract is set when no borrow occurred (a >= b)
        full  = {1'b0, i_req.a} + {1'b0, b_eff}
              + {{SER_W{1'b0}}, (i_req.op == ALU_SUB)};
        o_rsp.sum   = full[SER_W-1:0];
        o_rsp.carry = full[SER_W];
    end
endmodule
`default_nettype wire

// File: verif/setr_checker.sv
// Result checker for the event trace ring: predicts every result beat and compares it.
`timescale 1ns / 1ps
module setr_checker
    import setr_pkg::*;
#(
    parameter int DEPTH = 32
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic                      i_busy,
    input  wire logic                      i_cfg_we,
    input  wire logic [TYPE_W-1:0]         i_cfg_wdata,
    input  wire logic                      i_func,
    input  wire logic [TYPE_W-1:0]         i_event_type,
    input  wire logic [ADDR_W-1:0]         i_actor_address,
    input  wire logic signed [DATA_W-1:0]  i_actor_index,
    input  wire logic signed [DATA_W-1:0]  i_old_stat,
    input  wire logic signed [DATA_W-1:0]  i_new_stat,
    input  wire logic signed [DATA_W-1:0]  i_sector_index,
    input  wire logic [SER_W-1:0]          i_cursor,
    input  wire logic                      i_valid,
    input  wire logic [KIND_W-1:0]         i_kind,
    input  wire logic [SER_W-1:0]          i_serial,
    input  wire logic [SER_W-1:0]          i_oldest_serial,
    input  wire logic                      i_overflowed,
    input  wire logic [EPOCH_W-1:0]        i_epoch,
    input  wire logic [TYPE_W-1:0]         i_out_type,
    input  wire logic [ADDR_W-1:0]         i_out_address,
    input  wire logic signed [DATA_W-1:0]  i_out_actor_index,
    input  wire logic signed [DATA_W-1:0]  i_out_sector,
    input  wire logic signed [DATA_W-1:0]  i_out_old_stat,
    input  wire logic signed [DATA_W-1:0]  i_out_new_stat,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_checked
);

    typedef struct {
        logic [KIND_W-1:0]  kind;
        logic [SER_W-1:0]   serial;
        logic [SER_W-1:0]   oldest;
        logic               over;
        logic [EPOCH_W-1:0] epoch;
        logic [TYPE_W-1:0]  etype;
        logic [ADDR_W-1:0]  address;
        logic [DATA_W-1:0]  actor_index;
        logic [DATA_W-1:0]  sector;
        logic [DATA_W-1:0]  old_stat;
        logic [DATA_W-1:0]  new_stat;
    } t_trace_beat;

    t_trace_beat        beats_due[$];
    logic [TYPE_W-1:0]  world_reset_code;
    logic [SER_W-1:0]   last_serial;
    logic [EPOCH_W-1:0] epoch_now;
    int unsigned        fill;
    int unsigned        wr_ptr;
    logic [SER_W-1:0]   slot_serial_q [DEPTH];
    t_slot              slot_q [DEPTH];

    function automatic t_trace_beat blank_beat(input logic [KIND_W-1:0] kind,
                                               input logic [SER_W-1:0] serial);
        t_trace_beat b;
        b.kind        = kind;
        b.serial      = serial;
        b.oldest      = '0;
        b.over        = 1'b0;
        b.epoch       = '0;
        b.etype       = '0;
        b.address     = '0;
        b.actor_index = '0;
        b.sector      = '0;
        b.old_stat    = '0;
        b.new_stat    = '0;
        return b;
    endfunction

    function automatic string describe(input t_trace_beat b);
        return $sformatf({"kind %0d serial %0h oldest %0h over %0b epoch %0h type %0h",
                          " addr %0h actor %0h sector %0h old %0h new %0h"},
                         b.kind, b.serial, b.oldest, b.over, b.epoch, b.etype,
                         b.address, b.actor_index, b.sector, b.old_stat, b.new_stat);
    endfunction

    // Append one expected beat at the tail of the queue.
    task automatic enqueue_beat(input t_trace_beat b);
        beats_due.insert(beats_due.size(), b);
    endtask

    // Store one record and queue its acknowledge.
    task automatic log_event();
        t_slot rec;
        if (i_event_type == world_reset_code) begin
            epoch_now = epoch_now + 1'b1;
            if (epoch_now == '0)
                epoch_now = EPOCH_W'(1);
        end
        last_serial = last_serial + 1'b1;
        if (last_serial == '0) begin
            last_serial = SER_W'(1);
            fill        = 0;
            wr_ptr      = 0;
        end
        rec.epoch       = epoch_now;
        rec.etype       = i_event_type;
        rec.address     = i_actor_address;
        rec.actor_index = i_actor_index;
        rec.sector      = i_sector_index;
        rec.old_stat    = i_old_stat;
        rec.new_stat    = i_new_stat;
        slot_serial_q[wr_ptr] = last_serial;
        slot_q[wr_ptr]        = rec;
        wr_ptr = (wr_ptr + 1 == DEPTH) ? 0 : wr_ptr + 1;
        if (fill < DEPTH)
            fill++;
        enqueue_beat(blank_beat(KIND_ACK, last_serial));
    endtask

    // Queue every live event newer than the cursor, oldest first, then the summary.
    task automatic replay_after(input logic [SER_W-1:0] cursor);
        logic [SER_W-1:0] oldest;
        logic [SER_W-1:0] s;
        logic [SER_W-1:0] remaining;
        logic             over;
        int               n;
        int               idx;
        int               offset;
        t_trace_beat      b;
        oldest = '0;
        over   = 1'b0;
        n      = 0;
        if (fill != 0) begin
            oldest = last_serial - SER_W'(fill) + 1'b1;
            if (cursor < last_serial) begin
                s = cursor + 1'b1;
                if (s < oldest) begin
                    over = 1'b1;
                    s    = oldest;
                end
                remaining = last_serial - s + 1'b1;
                while (remaining != 0 && n < DEPTH) begin
                    offset = int'(last_serial - s);
                    idx    = (int'(wr_ptr) + DEPTH - 1 - offset) % DEPTH;
                    if (slot_serial_q[idx] == s) begin
                        b             = blank_beat(KIND_EVENT, s);
                        b.epoch       = slot_q[idx].epoch;
                        b.etype       = slot_q[idx].etype;
                        b.address     = slot_q[idx].address;
                        b.actor_index = slot_q[idx].actor_index;
                        b.sector      = slot_q[idx].sector;
                        b.old_stat    = slot_q[idx].old_stat;
                        b.new_stat    = slot_q[idx].new_stat;
                        enqueue_beat(b);
                        n++;
                    end
                    s         = s + 1'b1;
                    remaining = remaining - 1'b1;
                end
            end
        end
        b        = blank_beat(KIND_SUM, last_serial);
        b.oldest = oldest;
        b.over   = over;
        enqueue_beat(b);
    endtask

    task automatic check_beat();
        t_trace_beat got;
        t_trace_beat want;
        got.kind        = i_kind;
        got.serial      = i_serial;
        got.oldest      = i_oldest_serial;
        got.over        = i_overflowed;
        got.epoch       = i_epoch;
        got.etype       = i_out_type;
        got.address     = i_out_address;
        got.actor_index = i_out_actor_index;
        got.sector      = i_out_sector;
        got.old_stat    = i_out_old_stat;
        got.new_stat    = i_out_new_stat;
        o_checked++;
        if (beats_due.size() == 0) begin
            o_fail_count++;
            if (o_fail_count <= 10)
                $display("beat %0d arrived with nothing outstanding: %s",
                         o_checked, describe(got));
        end else begin
            want = beats_due.pop_front();
            if (got.kind !== want.kind || got.serial !== want.serial ||
                got.oldest !== want.oldest || got.over !== want.over ||
                got.epoch !== want.epoch || got.etype !== want.etype ||
                got.address !== want.address || got.actor_index !== want.actor_index ||
                got.sector !== want.sector || got.old_stat !== want.old_stat ||
                got.new_stat !== want.new_stat) begin
                o_fail_count++;
                if (o_fail_count <= 10) begin
                    $display("mismatch on beat %0d", o_checked);
                    $display("  expected %s", describe(want));
                    $display("  actual   %s", describe(got));
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            world_reset_code = '0;
            last_serial      = '0;
            epoch_now        = '0;
            fill             = 0;
            wr_ptr           = 0;
            o_fail_count     = 0;
            o_checked        = 0;
            for (int k = 0; k < DEPTH; k++)
                slot_serial_q[k] = '0;
            beats_due.delete();
        end else begin
            if (i_valid)
                check_beat();
            // a beat taken on this edge still sees the old reset code
            if (i_start && !i_busy) begin
                if (i_func == FUNC_RECORD)
                    log_event();
                else
                    replay_after(i_cursor);
            end
            if (i_cfg_we)
                world_reset_code = i_cfg_wdata;
        end
        o_pending = beats_due.size();
    end

endmodule

// File: verif/sequenced_event_trace_ring_unit_test.sv
// Testbench top for the event trace ring: stimulus, clock, reset and the final verdict.
`timescale 1ns / 1ps
module sequenced_event_trace_ring_unit_test;
    import setr_pkg::*;

    localparam int DEPTH    = 32;
    localparam int LIMIT    = 400000;   // cycles
    localparam int GAP_PCT  = 25;       // chance of a gap after a beat, in percent
    localparam int PER_PASS = 92;       // random items per reset-code setting

    // Every input starts at a known value; reset is held from time zero.
    logic                      i_clk           = 1'b0;
    logic                      i_rst_n         = 1'b0;
    logic                      start           = 1'b0;
    logic                      i_cfg_we        = 1'b0;
    logic [TYPE_W-1:0]         i_cfg_wdata     = '0;
    logic                      i_func          = FUNC_RECORD;
    logic [TYPE_W-1:0]         i_event_type    = '0;
    logic [ADDR_W-1:0]         i_actor_address = '0;
    logic signed [DATA_W-1:0]  i_actor_index   = '0;
    logic signed [DATA_W-1:0]  i_old_stat      = '0;
    logic signed [DATA_W-1:0]  i_new_stat      = '0;
    logic signed [DATA_W-1:0]  i_sector_index  = '0;
    logic [SER_W-1:0]          i_cursor        = '0;

    logic                      busy;
    logic                      o_valid;
    logic [KIND_W-1:0]         o_kind;
    logic [SER_W-1:0]          o_serial;
    logic [SER_W-1:0]          o_oldest_serial;
    logic                      o_overflowed;
    logic [EPOCH_W-1:0]        o_epoch;
    logic [TYPE_W-1:0]         o_out_type;
    logic [ADDR_W-1:0]         o_out_address;
    logic signed [DATA_W-1:0]  o_out_actor_index;
    logic signed [DATA_W-1:0]  o_out_sector;
    logic signed [DATA_W-1:0]  o_out_old_stat;
    logic signed [DATA_W-1:0]  o_out_new_stat;

    int                        fail_count;
    int                        beats_pending;
    int                        beats_checked;

    int                        records_sent  = 0;
    int                        reads_sent    = 0;
    int                        codes_written = 0;
    int                        cycles        = 0;
    bit                        steady        = 1'b0;   // no gaps while set
    logic [TYPE_W-1:0]         reset_code_now = '0;

    always #1 i_clk = ~i_clk;

    sequenced_event_trace_ring_unit #(
        .DEPTH(DEPTH)
    ) u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_func            (i_func),
        .i_event_type      (i_event_type),
        .i_actor_address   (i_actor_address),
        .i_actor_index     (i_actor_index),
        .i_old_stat        (i_old_stat),
        .i_new_stat        (i_new_stat),
        .i_sector_index    (i_sector_index),
        .i_cursor          (i_cursor),
        .o_valid           (o_valid),
        .o_kind            (o_kind),
        .o_serial          (o_serial),
        .o_oldest_serial   (o_oldest_serial),
        .o_overflowed      (o_overflowed),
        .o_epoch           (o_epoch),
        .o_out_type        (o_out_type),
        .o_out_address     (o_out_address),
        .o_out_actor_index (o_out_actor_index),
        .o_out_sector      (o_out_sector),
        .o_out_old_stat    (o_out_old_stat),
        .o_out_new_stat    (o_out_new_stat)
    );

    // The trace checker watches both sides of the block and keeps its own ring.
    setr_checker #(
        .DEPTH(DEPTH)
    ) u_trace_check (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (start),
        .i_busy            (busy),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_func            (i_func),
        .i_event_type      (i_event_type),
        .i_actor_address   (i_actor_address),
        .i_actor_index     (i_actor_index),
        .i_old_stat        (i_old_stat),
        .i_new_stat        (i_new_stat),
        .i_sector_index    (i_sector_index),
        .i_cursor          (i_cursor),
        .i_valid           (o_valid),
        .i_kind            (o_kind),
        .i_serial          (o_serial),
        .i_oldest_serial   (o_oldest_serial),
        .i_overflowed      (o_overflowed),
        .i_epoch           (o_epoch),
        .i_out_type        (o_out_type),
        .i_out_address     (o_out_address),
        .i_out_actor_index (o_out_actor_index),
        .i_out_sector      (o_out_sector),
        .i_out_old_stat    (o_out_old_stat),
        .i_out_new_stat    (o_out_new_stat),
        .o_fail_count      (fail_count),
        .o_pending         (beats_pending),
        .o_checked         (beats_checked)
    );

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Present one beat and hold it until the block takes it. Called just after a
    // rising edge; returns at the edge that accepted the beat, or a few idle cycles
    // later when a gap is drawn.
    task automatic issue(input logic                     func,
                         input logic [TYPE_W-1:0]        etype,
                         input logic [ADDR_W-1:0]        addr,
                         input logic signed [DATA_W-1:0] actor,
                         input logic signed [DATA_W-1:0] old_s,
                         input logic signed [DATA_W-1:0] new_s,
                         input logic signed [DATA_W-1:0] sector,
                         input logic [SER_W-1:0]         cursor);
        start           <= 1'b1;
        i_func          <= func;
        i_event_type    <= etype;
        i_actor_address <= addr;
        i_actor_index   <= actor;
        i_old_stat      <= old_s;
        i_new_stat      <= new_s;
        i_sector_index  <= sector;
        i_cursor        <= cursor;
        // Accepted at the first edge that sees busy low.
        do @(posedge i_clk); while (busy);
        if (func == FUNC_RECORD)
            records_sent++;
        else
            reads_sent++;
        // Drop start for a short random gap; keep it high for back-to-back beats.
        if (!steady && $urandom_range(99) < GAP_PCT) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    // Record an event; the cursor is ignored by the block, so randomize it.
    task automatic record_event(input logic [TYPE_W-1:0]        etype,
                                input logic [ADDR_W-1:0]        addr,
                                input logic signed [DATA_W-1:0] actor,
                                input logic signed [DATA_W-1:0] old_s,
                                input logic signed [DATA_W-1:0] new_s,
                                input logic signed [DATA_W-1:0] sector);
        issue(FUNC_RECORD, etype, addr, actor, old_s, new_s, sector, {$urandom, $urandom});
    endtask

    // Read after a cursor; the record fields are ignored, so randomize them.
    task automatic read_after(input logic [SER_W-1:0] cursor);
        issue(FUNC_READ, TYPE_W'($urandom_range(15)), {$urandom, $urandom},
              $urandom, $urandom, $urandom, $urandom, cursor);
    endtask

    // Random record; bias the type toward the current reset code to bump the epoch.
    task automatic random_record();
        logic [TYPE_W-1:0] etype;
        etype = ($urandom_range(3) == 0) ? reset_code_now : TYPE_W'($urandom_range(15));
        record_event(etype, {$urandom, $urandom}, $urandom, $urandom, $urandom, $urandom);
    endtask

    // Mostly cursors a little behind the head, so reads walk deep into the ring
    // and often reach past the oldest live event; the rest are edge cursors.
    function automatic logic [SER_W-1:0] pick_cursor();
        logic [SER_W-1:0] head;
        logic [SER_W-1:0] back;
        head = SER_W'(records_sent);
        back = SER_W'($urandom_range(40));
        case ($urandom_range(9))
            0:       return '0;
            1:       return head;
            2:       return head + SER_W'($urandom_range(1, 3));
            3:       return {$urandom, $urandom};
            default: return (back > head) ? '0 : head - back;
        endcase
    endfunction

    // Hold off the sender until every expected beat is in and the block is idle.
    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (beats_pending != 0 || busy);
    endtask

    // Drain, then write the reset type code while nothing is in flight.
    task automatic set_reset_code(input logic [TYPE_W-1:0] code);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= code;
        @(posedge i_clk);
        i_cfg_we       <= 1'b0;
        reset_code_now  = code;
        codes_written++;
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: empty ring, field extremes, epoch bumps, every cursor case.
        set_reset_code(4'd0);
        read_after('0);                                 // empty ring, summary only
        read_after('1);
        record_event(4'd0, '0, '0, '0, '0, '0);         // matches the reset code
        record_event(4'd15, '1, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        record_event(4'd0, 64'h8000_0000_0000_0000,
                     32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        record_event(4'd9, 64'h5555_aaaa_5555_aaaa, -1, -1, -1, -1);
        read_after('0);                                 // whole ring
        read_after(64'd2);                              // newest two
        read_after(64'd4);                              // cursor at head
        read_after('1);                                 // cursor past head
        read_after(64'd3);
        set_reset_code(4'd15);
        record_event(4'd15, {$urandom, $urandom}, $urandom, $urandom, $urandom, $urandom);
        record_event(4'd0, {$urandom, $urandom}, $urandom, $urandom, $urandom, $urandom);
        read_after('0);

        // Random part: several reset-code settings, one pass with no gaps at all.
        for (int pass = 0; pass < 4; pass++) begin
            case (pass)
                0:       set_reset_code(TYPE_W'($urandom_range(1, 14)));
                1:       set_reset_code(4'd15);
                2:       set_reset_code(4'd0);
                default: set_reset_code(TYPE_W'($urandom_range(15)));
            endcase
            steady = (pass == 1);
            for (int k = 0; k < PER_PASS; k++) begin
                if ($urandom_range(3) == 0)
                    read_after(pick_cursor());
                else
                    random_record();
            end
        end
        steady = 1'b0;

        // Wait out every outstanding beat, then a little longer for strays.
        drain();
        repeat (16) @(posedge i_clk);

        $display("covered %0d records and %0d reads under %0d reset-code writes",
                 records_sent, reads_sent, codes_written);
        $display("%0d result beats checked, %0d mismatched or unexpected",
                 beats_checked, fail_count);
        if (fail_count == 0 && beats_pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
